@@ sv/rstu_pkg.sv @@
// ----------------------------------------------------------------------------
// rstu_pkg: shared types and constants of the radix string parser
// Phase and radix codes, character codes, mode codes and the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

package rstu_pkg;

    // Radix mode register codes
    localparam logic [2:0] MODE_AUTO = 3'd0;
    localparam logic [2:0] MODE_BIN  = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_DEC  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_UP_B   = 8'h42;

    // Digit value offset of the letters a..f
    localparam logic [3:0] LETTER_BASE = 4'd10;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RX_BIN = 2'd0,
        RX_OCT = 2'd1,
        RX_DEC = 2'd2,
        RX_HEX = 2'd3
    } t_radix;

    typedef struct packed {
        t_phase      phase;
        logic        negative;
        logic [31:0] acc;
        t_radix      radix;
    } t_parse_state;

    // Parse state at the start of a string for a given mode
    function automatic t_parse_state restart_state(input logic [2:0] mode);
        t_parse_state s;
        s.phase    = PH_SPACE;
        s.negative = 1'b0;
        s.acc      = '0;
        case (mode)
            MODE_BIN: s.radix = RX_BIN;
            MODE_OCT: s.radix = RX_OCT;
            MODE_HEX: s.radix = RX_HEX;
            default:  s.radix = RX_DEC;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ sv/radix_string_to_uint32_core.sv @@
// ----------------------------------------------------------------------------
// radix_string_to_uint32_core: streaming string to 32-bit integer parser
// Character stream in, one unsigned value per string out, bases 2/8/10/16.
// ----------------------------------------------------------------------------
// The block takes one character per cycle. While a finished value waits on the
// output it keeps taking characters, up to and including the last character of
// the next string; that character then stalls in the input register until the
// waiting value has been transferred. A character passes through an input
// register and then one parse step (a shift-and-add multiply by the radix plus
// the digit) that updates the running state. The value of a string passes from
// the input register to the output register once the output is free. The
// combinational multiply-add on the accumulator sets the rate of one character
// per clock while nothing stalls. The radix mode register may be written only
// while no string is in flight; a write restarts the parse. Modes 5 to 7 give
// a value of zero.
`default_nettype none

module radix_string_to_uint32_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Radix mode write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_data,     // radix_mode
    // Character stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // last
    // Value stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] value
);

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_last;
    logic [2:0]             r_mode;
    rstu_pkg::t_parse_state r_state;
    rstu_pkg::t_parse_state n_state;
    rstu_pkg::t_parse_state step_state;
    logic                   r_out_valid;
    logic [31:0]            r_out_value;
    logic [31:0]            n_out_value;
    logic                   out_free;
    logic                   advance;
    logic                   mode_ok;

    // One parse step on the registered character
    rstu_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_mode  (r_mode),
        .o_state (step_state)
    );

    // Handshake: the step runs unless a value is due and the output is full
    always_comb begin
        out_free      = !r_out_valid || m_axis_tready;
        advance       = r_in_valid && (!r_in_last || out_free);
        s_axis_tready = !r_in_valid || advance;
        o_cfg_ready   = !r_in_valid;
        mode_ok       = (r_mode <= rstu_pkg::MODE_HEX);
    end

    // Next parse state and the value of a finished string
    always_comb begin
        n_state = mode_ok ? step_state : r_state;
        if (!mode_ok) begin
            n_out_value = '0;
        end else if (n_state.negative) begin
            n_out_value = ~n_state.acc + 32'd1;
        end else begin
            n_out_value = n_state.acc;
        end
        if (r_in_last) begin
            n_state = rstu_pkg::restart_state(r_mode);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Mode register and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rstu_pkg::MODE_AUTO;
            r_state <= rstu_pkg::restart_state(rstu_pkg::MODE_AUTO);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode  <= i_cfg_data;
            r_state <= rstu_pkg::restart_state(i_cfg_data);
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register: load on the last character, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_value <= n_out_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;

endmodule

`default_nettype wire

@@ sv/rstu_step.sv @@
// ----------------------------------------------------------------------------
// rstu_step: one character step of the parser
// Combinational next parse state for one character under the current mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rstu_step (
    input  wire rstu_pkg::t_parse_state i_state,
    input  wire logic [7:0]             i_char,
    input  wire logic [2:0]             i_mode,
    output rstu_pkg::t_parse_state      o_state
);

    logic             is_space;
    logic             is_x;
    logic             is_b;
    logic             dec_char;
    logic             lo_char;
    logic             up_char;
    logic [3:0]       digit;
    logic             digit_ok;
    logic             take_digit;
    rstu_pkg::t_radix eff_radix;
    logic [31:0]      acc_next;

    // Classify the character
    always_comb begin
        is_space = (i_char == rstu_pkg::CH_SPACE) ||
                   (i_char >= rstu_pkg::CH_TAB && i_char <= rstu_pkg::CH_CR);
        is_x     = (i_char == rstu_pkg::CH_LO_X) || (i_char == rstu_pkg::CH_UP_X);
        is_b     = (i_char == rstu_pkg::CH_LO_B) || (i_char == rstu_pkg::CH_UP_B);
        dec_char = (i_char >= rstu_pkg::CH_ZERO) && (i_char <= rstu_pkg::CH_NINE);
        lo_char  = (i_char >= rstu_pkg::CH_LO_A) && (i_char <= rstu_pkg::CH_LO_F);
        up_char  = (i_char >= rstu_pkg::CH_UP_A) && (i_char <= rstu_pkg::CH_UP_F);
    end

    // Phase decode: choose the radix in effect and whether a digit is taken
    always_comb begin
        o_state    = i_state;
        eff_radix  = i_state.radix;
        take_digit = 1'b0;
        unique case (i_state.phase)
            rstu_pkg::PH_SPACE, rstu_pkg::PH_PREFIX: begin
                if (i_state.phase == rstu_pkg::PH_SPACE && is_space) begin
                    o_state = i_state;
                end else if (i_state.phase == rstu_pkg::PH_SPACE &&
                             i_char == rstu_pkg::CH_MINUS) begin
                    o_state.negative = 1'b1;
                    o_state.phase    = rstu_pkg::PH_PREFIX;
                end else if (i_char == rstu_pkg::CH_ZERO) begin
                    o_state.acc   = '0;
                    o_state.phase = rstu_pkg::PH_ZERO;
                end else begin
                    if (i_mode == rstu_pkg::MODE_AUTO) begin
                        eff_radix = rstu_pkg::RX_DEC;
                    end
                    take_digit = 1'b1;
                end
            end
            rstu_pkg::PH_ZERO: begin
                if (is_x && (i_mode == rstu_pkg::MODE_AUTO ||
                             i_mode == rstu_pkg::MODE_HEX)) begin
                    o_state.radix = rstu_pkg::RX_HEX;
                    o_state.phase = rstu_pkg::PH_DIGITS;
                end else if (is_b && (i_mode == rstu_pkg::MODE_AUTO ||
                                      i_mode == rstu_pkg::MODE_BIN)) begin
                    o_state.radix = rstu_pkg::RX_BIN;
                    o_state.phase = rstu_pkg::PH_DIGITS;
                end else begin
                    if (i_mode == rstu_pkg::MODE_AUTO) begin
                        eff_radix = rstu_pkg::RX_OCT;
                    end
                    take_digit = 1'b1;
                end
            end
            rstu_pkg::PH_DIGITS: begin
                take_digit = 1'b1;
            end
            default: begin
                o_state = i_state;
            end
        endcase

        // Digit value and its validity in the radix in effect
        if (dec_char) begin
            digit = 4'(i_char - rstu_pkg::CH_ZERO);
        end else if (lo_char) begin
            digit = 4'(i_char - rstu_pkg::CH_LO_A) + rstu_pkg::LETTER_BASE;
        end else if (up_char) begin
            digit = 4'(i_char - rstu_pkg::CH_UP_A) + rstu_pkg::LETTER_BASE;
        end else begin
            digit = '0;
        end

        case (eff_radix)
            rstu_pkg::RX_BIN: begin
                digit_ok = dec_char && (digit < 4'd2);
                acc_next = {i_state.acc[30:0], 1'b0} + {28'd0, digit};
            end
            rstu_pkg::RX_OCT: begin
                digit_ok = dec_char && (digit < 4'd8);
                acc_next = {i_state.acc[28:0], 3'd0} + {28'd0, digit};
            end
            rstu_pkg::RX_DEC: begin
                digit_ok = dec_char;
                acc_next = {i_state.acc[28:0], 3'd0} + {i_state.acc[30:0], 1'b0}
                           + {28'd0, digit};
            end
            default: begin
                digit_ok = dec_char || lo_char || up_char;
                acc_next = {i_state.acc[27:0], 4'd0} + {28'd0, digit};
            end
        endcase

        // Accumulate a digit or stop at the first non-digit
        if (take_digit) begin
            o_state.radix = eff_radix;
            if (digit_ok) begin
                o_state.acc   = acc_next;
                o_state.phase = rstu_pkg::PH_DIGITS;
            end else begin
                o_state.phase = rstu_pkg::PH_DONE;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/rstu_checker.sv @@
// ----------------------------------------------------------------------------
// rstu_checker: port-level checks of the parser
// Watches reset, back-pressure and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rstu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Input stalls only while a value waits on the output
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A value waiting for transfer stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output value changed before transfer");

endmodule

bind radix_string_to_uint32_core rstu_checker u_rstu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/rstu_value_check.sv @@
// ----------------------------------------------------------------------------
// rstu_value_check: value predictor and comparator for the radix parser
// Watches the radix mode, character and value channels, works out the value
// that each string should give and compares every value transfer with it.
// ----------------------------------------------------------------------------

module rstu_value_check
    import rstu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_value,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] DEC_BASE = 32'd10;
    localparam int          MAX_PRINTS = 25;

    // Predicted parse state and the mode it runs under
    logic [2:0]  mode_q;
    t_phase      phase_q;
    logic        minus_q;
    logic [31:0] acc_q;
    t_radix      radix_q;

    logic [31:0] expected_values[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_values.size();

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS) begin
            $display("[%0t] value check: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    // Return to the start of a string under the current mode
    task automatic restart_parse();
        phase_q = PH_SPACE;
        minus_q = 1'b0;
        acc_q   = '0;
        case (mode_q)
            MODE_BIN: radix_q = RX_BIN;
            MODE_OCT: radix_q = RX_OCT;
            MODE_HEX: radix_q = RX_HEX;
            default:  radix_q = RX_DEC;
        endcase
    endtask

    // Take one digit of the active radix, or stop the parse
    task automatic take_digit(input logic [7:0] c);
        logic [4:0] d;
        logic       ok;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d  = 5'(c - CH_ZERO);
            ok = 1'b1;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d  = 5'(c - CH_LO_A + LETTER_BASE);
            ok = (radix_q == RX_HEX);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d  = 5'(c - CH_UP_A + LETTER_BASE);
            ok = (radix_q == RX_HEX);
        end else begin
            d  = '0;
            ok = 1'b0;
        end
        if (ok) begin
            case (radix_q)
                RX_BIN:  ok = (d < 5'd2);
                RX_OCT:  ok = (d < 5'd8);
                RX_DEC:  ok = (d < 5'd10);
                default: ok = (d < 5'd16);
            endcase
        end
        if (!ok) begin
            phase_q = PH_DONE;
        end else begin
            case (radix_q)
                RX_BIN:  acc_q = (acc_q << 1) + 32'(d);
                RX_OCT:  acc_q = (acc_q << 3) + 32'(d);
                RX_DEC:  acc_q = acc_q * DEC_BASE + 32'(d);
                default: acc_q = (acc_q << 4) + 32'(d);
            endcase
            phase_q = PH_DIGITS;
        end
    endtask

    // Character after a leading zero: radix prefix letter or first digit
    task automatic take_after_zero(input logic [7:0] c);
        logic is_x;
        logic is_b;
        is_x = (c == CH_LO_X) || (c == CH_UP_X);
        is_b = (c == CH_LO_B) || (c == CH_UP_B);
        if (is_x && (mode_q == MODE_AUTO || mode_q == MODE_HEX)) begin
            radix_q = RX_HEX;
            phase_q = PH_DIGITS;
        end else if (is_b && (mode_q == MODE_AUTO || mode_q == MODE_BIN)) begin
            radix_q = RX_BIN;
            phase_q = PH_DIGITS;
        end else begin
            if (mode_q == MODE_AUTO) radix_q = RX_OCT;
            take_digit(c);
        end
    endtask

    task automatic take_lead(input logic [7:0] c);
        if (c == CH_ZERO) begin
            acc_q   = '0;
            phase_q = PH_ZERO;
        end else begin
            if (mode_q == MODE_AUTO) radix_q = RX_DEC;
            take_digit(c);
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        case (phase_q)
            PH_SPACE: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    // skip leading whitespace
                end else if (c == CH_MINUS) begin
                    minus_q = 1'b1;
                    phase_q = PH_PREFIX;
                end else begin
                    take_lead(c);
                end
            end
            PH_PREFIX: take_lead(c);
            PH_ZERO:   take_after_zero(c);
            PH_DIGITS: take_digit(c);
            default: ;
        endcase
    endtask

    // Follow every transfer at the rising edge
    always @(posedge i_clk) begin
        logic [31:0] v;
        if (!i_rst_n) begin
            mode_q     = MODE_AUTO;
            fail_count = 0;
            expected_values.delete();
            restart_parse();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                mode_q = i_cfg_data;
                restart_parse();
            end
            if (i_in_valid && i_in_ready) begin
                if (mode_q <= MODE_HEX) take_char(i_in_char);
                if (i_in_last) begin
                    if (mode_q > MODE_HEX) v = '0;
                    else                   v = minus_q ? (~acc_q + 32'd1) : acc_q;
                    expected_values.push_back(v);
                    restart_parse();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("value %h with no string pending",
                                              i_out_value));
                end else begin
                    v = expected_values.pop_front();
                    if (i_out_value !== v) begin
                        report_mismatch($sformatf("value %h, predicted %h",
                                                  i_out_value, v));
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the radix string to 32-bit value parser
// Feeds short directed strings, then runs of well-formed numbers with random
// content, noise and broken prefixes under every radix mode, with random
// gaps on both streams; rstu_value_check predicts and compares the values.
// ----------------------------------------------------------------------------

module tb_top;
    import rstu_pkg::*;

    // Mode codes the block treats as unsupported
    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;
    localparam int N_PHASES     = 9;
    localparam int FULL_BUDGET  = 120;
    localparam int RSVD_BUDGET  = 25;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_char;
    logic        in_last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_value;

    int          fail_count;
    int          pending;
    int          item_count;
    bit          calm;
    logic [7:0]  text_q[$];
    logic [2:0]  mode_seq[N_PHASES];

    radix_string_to_uint32_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_char),
        .s_axis_tlast  (in_last),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_value)
    );

    rstu_value_check value_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_char    (in_char),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_value  (out_value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Value side: stall at random
    initial begin
        int stall;
        out_ready = 1'b0;
        stall     = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Present one character and hold it until its transfer
    task automatic send_char(input logic [7:0] c, input logic lst);
        int gap;
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= lst;
        do @(posedge clk); while (!in_ready);
        item_count++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic hold_sender();
        in_valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_queue();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic wait_drained();
        hold_sender();
        while (pending != 0) @(negedge clk);
    endtask

    // Write the radix mode once the block has gone quiet
    task automatic write_mode(input logic [2:0] m);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input int digit);
        if (digit < 10) return CH_ZERO + 8'(digit);
        if ($urandom_range(0, 1) == 0) return CH_LO_A + 8'(digit - 10);
        return CH_UP_A + 8'(digit - 10);
    endfunction

    function automatic logic [7:0] space_char();
        if ($urandom_range(0, 2) == 0) return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // Number in the form the mode expects, with random digits and tail
    task automatic build_number(input logic [2:0] m);
        int  limit;
        int  n_dig;
        int  kind;
        bit  nonzero_lead;
        limit        = 10;
        nonzero_lead = 1'b0;
        repeat ($urandom_range(0, 3)) text_q.push_back(space_char());
        if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
        case (m)
            MODE_AUTO: begin
                kind = $urandom_range(0, 3);
                if (kind < 3) text_q.push_back(CH_ZERO);
                case (kind)
                    0: begin
                        text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                        limit = 16;
                    end
                    1: begin
                        text_q.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
                        limit = 2;
                    end
                    2: limit = 8;
                    default: nonzero_lead = 1'b1;
                endcase
            end
            MODE_BIN: begin
                limit = 2;
                if ($urandom_range(0, 1) == 0) begin
                    text_q.push_back(CH_ZERO);
                    text_q.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
                end
            end
            MODE_HEX: begin
                limit = 16;
                if ($urandom_range(0, 1) == 0) begin
                    text_q.push_back(CH_ZERO);
                    text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                end
            end
            MODE_OCT: limit = 8;
            default: ;
        endcase
        // Long runs wrap the accumulator
        n_dig = ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        for (int i = 0; i < n_dig; i++) begin
            if (i == 0 && nonzero_lead) text_q.push_back(digit_char($urandom_range(1, 9)));
            else                        text_q.push_back(digit_char($urandom_range(0, limit - 1)));
        end
        kind = $urandom_range(0, 3);
        if (kind >= 2) begin
            text_q.push_back(kind == 2 ? 8'h00 : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Radix prefix followed by a zero byte or a random byte
    task automatic build_broken();
        if ($urandom_range(0, 1) == 0) text_q.push_back(CH_MINUS);
        text_q.push_back(CH_ZERO);
        text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_LO_B);
        text_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int budget;
        int phase_start;
        int strings;
        int r;
        mode_seq = '{MODE_HEX, MODE_BIN, MODE_RSVD7, MODE_OCT, MODE_DEC,
                     MODE_RSVD5, MODE_AUTO, MODE_RSVD6, MODE_AUTO};
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = MODE_AUTO;
        in_valid   = 1'b0;
        in_char    = '0;
        in_last    = 1'b0;
        item_count = 0;
        calm       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings in auto mode after reset
        send_text("\t-0x1f");
        send_text("017");
        send_text("0B11");
        send_text("9z5");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_ZERO + 8'd7, 1'b1);
        send_text("0");
        send_text("-");

        // Random strings under each mode in turn
        for (int p = 0; p < N_PHASES; p++) begin
            write_mode(mode_seq[p]);
            budget      = (mode_seq[p] > MODE_HEX) ? RSVD_BUDGET : FULL_BUDGET;
            phase_start = item_count;
            strings     = 0;
            while (item_count - phase_start < budget) begin
                calm = ($urandom_range(0, 7) == 0);
                r = $urandom_range(0, 9);
                if (r < 7)      build_number(mode_seq[p]);
                else if (r < 9) build_noise();
                else            build_broken();
                send_queue();
                strings++;
                // Let the value stream run dry now and then
                if (strings % 15 == 0) wait_drained();
            end
            calm = 1'b0;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
